// ===== hdl/pst_pkg.sv =====
package pst_pkg;

    localparam int MAX_N   = 65536;
    localparam int ADDR_W  = $clog2(MAX_N);
    // Counters must hold the limit itself plus one stride past it.
    localparam int CNT_W   = ADDR_W + 1;
    // Outer index runs up to ceil(sqrt(MAX_N)).
    localparam int I_W     = (ADDR_W + 1) / 2 + 2;
    localparam int LIMIT_W = 17;
    localparam int VALUE_W = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_TEST  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SQ_CHECK,
        ST_STRIKE,
        ST_NEXT_I,
        ST_DONE
    } pst_state_t;

endpackage

// ===== hdl/pst_if.sv =====
interface pst_req_if import pst_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface pst_rsp_if;
    logic valid;
    logic ready;
    logic is_prime;
    logic in_range;
    logic build_done;

    modport source (output valid, output is_prime, output in_range, output build_done,
                    input ready);
    modport sink   (input valid, input is_prime, input in_range, input build_done,
                    output ready);
endinterface

interface pst_cfg_if import pst_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);
endinterface

// ===== hdl/prime_sieve_table.sv =====
// Prime sieve table: a one-bit primality map held in an on-chip memory.
// The req channel carries cmd and value. A build (cmd 0) rewrites the map
// for all numbers below the configured limit; a test (cmd 1) reads one bit.
// The rsp channel returns one transaction per request: is_prime, in_range
// and build_done. The cfg channel writes the limit and is always ready; the
// user must write it only while no request is in flight, and the block does
// not enforce this. A test is answered in the cycle after it is accepted,
// and tests may follow each other every cycle while rsp keeps up. A build is
// handled by one shared adder under a small sequencer that writes one memory
// entry per cycle while it fills or strikes: it first fills the map, then for
// every i with i*i below the limit L strikes the multiples of i from i*i
// upward, and then finishes. req is not ready during a build.
// Reset clears the built flag, drops any pending response and sets the
// limit to 65536; the map contents are undefined until the first build.
// When rsp stalls, the response register holds and req is not ready
// until the pending transaction has been taken.
module prime_sieve_table
    import pst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pst_req_if.sink     req,
    pst_rsp_if.source   rsp,
    pst_cfg_if.sink     cfg
);

    logic prime_map [MAX_N];

    pst_state_t       state_reg, state_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] sq_reg, sq_next;
    logic [I_W-1:0]   i_reg, i_next;
    logic             map_built_reg, map_built_next;
    logic [LIMIT_W-1:0] limit_reg;

    logic             out_valid_reg, out_valid_next;
    logic             ok_reg, ok_next;
    logic             build_reg, build_next;
    logic             rd_bit_reg;

    logic             slot_free;
    logic             req_take;
    logic [CNT_W-1:0] lim_eff;
    logic [CNT_W-1:0] add_a, add_b, add_sum;
    logic             add_cin;
    logic             mem_we, mem_wdata, mem_re;
    logic [ADDR_W-1:0] mem_waddr;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        if (32'(limit_reg) > 32'(MAX_N))
            lim_eff = CNT_W'(MAX_N);
        else
            lim_eff = CNT_W'(limit_reg);
    end

    // The one adder of the sequencer: fill count, stride step and square update.
    assign add_sum = add_a + add_b + CNT_W'(add_cin);

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign req_take  = req.valid && req.ready;
    assign mem_re    = req_take && (req.cmd == CMD_TEST);

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        sq_next        = sq_reg;
        i_next         = i_reg;
        map_built_next = map_built_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        ok_next        = ok_reg;
        build_next     = build_reg;
        add_a          = j_reg;
        add_b          = CNT_W'(1);
        add_cin        = 1'b0;
        mem_we         = 1'b0;
        mem_wdata      = 1'b0;
        mem_waddr      = j_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    if (req.cmd == CMD_BUILD)
                    begin
                        j_next     = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        build_next     = 1'b0;
                        ok_next        = map_built_reg && (CNT_W'(req.value) < lim_eff);
                    end
                end
            end
            ST_FILL:
            begin
                if (j_reg < lim_eff)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = (j_reg >= CNT_W'(2));
                    j_next    = add_sum;
                end
                else
                begin
                    i_next     = I_W'(2);
                    sq_next    = CNT_W'(4);
                    state_next = ST_SQ_CHECK;
                end
            end
            ST_SQ_CHECK:
            begin
                if (sq_reg < lim_eff)
                begin
                    j_next     = sq_reg;
                    state_next = ST_STRIKE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_STRIKE:
            begin
                add_b = CNT_W'(i_reg);
                if (j_reg < lim_eff)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = 1'b0;
                    j_next    = add_sum;
                end
                else
                begin
                    state_next = ST_NEXT_I;
                end
            end
            ST_NEXT_I:
            begin
                // (i+1)^2 = i^2 + 2i + 1
                add_a      = sq_reg;
                add_b      = CNT_W'({i_reg, 1'b0});
                add_cin    = 1'b1;
                sq_next    = add_sum;
                i_next     = i_reg + I_W'(1);
                state_next = ST_SQ_CHECK;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    map_built_next = 1'b1;
                    out_valid_next = 1'b1;
                    ok_next        = 1'b1;
                    build_next     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            map_built_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            map_built_reg <= map_built_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                limit_reg <= cfg.limit;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        sq_reg    <= sq_next;
        i_reg     <= i_next;
        ok_reg    <= ok_next;
        build_reg <= build_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            prime_map[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_bit_reg <= prime_map[ADDR_W'(req.value)];
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.is_prime   = rd_bit_reg && ok_reg && !build_reg;
    assign rsp.in_range   = ok_reg;
    assign rsp.build_done = build_reg;

endmodule
